// ----- hdl/spm_pkg.sv -----
// shared constants, types and helpers for the streaming pattern matcher
`default_nettype none

package spm_pkg;

  localparam int PAT_MAX   = 16;
  localparam int WIN       = PAT_MAX - 1;
  localparam int LEN_W     = $clog2(PAT_MAX + 1);
  localparam int SEEN_W    = (WIN > 1) ? $clog2(WIN + 1) : 1;
  localparam int POS_W     = 32;
  localparam int TOTAL_W   = 32;
  localparam int REG_BYTES = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = CFG_IDX_W'(2);

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   start;
    logic [TOTAL_W-1:0] total;
  } result_t;

  // bytes past the register pair read as zero
  function automatic logic [7:0] pattern_byte(input logic [8*REG_BYTES-1:0] pat,
                                              input logic [LEN_W-1:0] idx);
    logic [7:0] b;
    b = 8'd0;
    for (int i = 0; i < REG_BYTES; i++) begin
      if (32'(idx) == i) begin
        b = pat[8*i +: 8];
      end
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/spm_cell.sv -----
// one window cell: holds a text byte, passes it on and compares it
`default_nettype none

module spm_cell (
  input  wire logic       clk,
  input  wire logic       shift_en,
  input  wire logic [7:0] byte_in,
  input  wire logic       care,
  input  wire logic [7:0] expect_byte,
  output logic      [7:0] byte_out,
  output logic            eq
);

  logic [7:0] held;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      held <= byte_in;
    end
  end

  assign byte_out = held;
  assign eq       = !care || (held == expect_byte);

endmodule

`default_nettype wire

// ----- hdl/spm_out_buf.sv -----
// result register with a skid stage so one more input word is taken under stall
`default_nettype none

module spm_out_buf (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire spm_pkg::result_t res_in,
  output logic                 can_load,
  output logic                 skid_valid,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output spm_pkg::result_t     res_out
);

  spm_pkg::result_t skid;

  assign can_load = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= load;
      end
    end else if (load) begin
      skid_valid <= 1'b1;
    end
  end

  // payload path, no reset
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        res_out <= skid;
      end else if (load) begin
        res_out <= res_in;
      end
    end else if (load) begin
      skid <= res_in;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/streaming_pattern_matcher.sv -----
// streaming pattern matcher: window of byte cells compared against the pattern
// each accepted word's result is registered in the result buffer, via the skid stage under stall
// throughput: one word per cycle while the result buffer has room; all cells compare in parallel with the new byte
// a two-entry result buffer keeps input accepted while one result is stalled
// reset: pattern registers to zero, length to one, counters and handshake cleared
// the window cells are not reset; the fill count keeps stale bytes from matching
`default_nettype none

module streaming_pattern_matcher (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [spm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [spm_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      text_byte,
  input  wire logic                            start_of_text,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 match_found,
  output logic [spm_pkg::POS_W-1:0]            match_start,
  output logic [spm_pkg::TOTAL_W-1:0]          match_total
);

  localparam int LW = spm_pkg::LEN_W;

  logic [63:0]                     pattern_low;
  logic [63:0]                     pattern_high;
  logic [LW-1:0]                   pattern_length;
  logic [spm_pkg::SEEN_W-1:0]      bytes_seen;
  logic [spm_pkg::POS_W-1:0]       text_position;
  logic [spm_pkg::TOTAL_W-1:0]     matches_so_far;

  logic                            accept;
  logic                            can_load;
  logic                            skid_valid;
  logic [LW-1:0]                   len_eff;
  logic [8*spm_pkg::REG_BYTES-1:0] pat;
  logic [spm_pkg::SEEN_W-1:0]      seen_eff;
  logic [spm_pkg::POS_W-1:0]       pos_eff;
  logic [spm_pkg::TOTAL_W-1:0]     count_eff;
  logic [spm_pkg::TOTAL_W-1:0]     count_next;
  logic                            hit;
  logic                            fill_ok;
  logic [7:0]                      chain [spm_pkg::WIN+1];
  logic [spm_pkg::WIN-1:0]         cell_eq;
  spm_pkg::result_t                res_in;
  spm_pkg::result_t                res_out;

  assign cfg_ready = 1'b1;
  assign in_ready  = can_load;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= spm_pkg::LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spm_pkg::REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        spm_pkg::REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        spm_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // zero length acts as one, anything past PAT_MAX is clipped to PAT_MAX
  always_comb begin
    if (pattern_length == '0) begin
      len_eff = LW'(1);
    end else if (32'(pattern_length) > spm_pkg::PAT_MAX) begin
      len_eff = LW'(spm_pkg::PAT_MAX);
    end else begin
      len_eff = pattern_length;
    end
  end

  assign pat       = {pattern_high, pattern_low};
  assign seen_eff  = start_of_text ? '0 : bytes_seen;
  assign pos_eff   = start_of_text ? '0 : text_position;
  assign count_eff = start_of_text ? '0 : matches_so_far;

  assign chain[0] = text_byte;

  // cell k holds the byte k+1 places back, checked against pattern byte len-2-k
  for (genvar k = 0; k < spm_pkg::WIN; k++) begin : g_cell
    logic          care;
    logic [LW-1:0] exp_idx;
    assign care    = (32'(len_eff) >= k + 2);
    assign exp_idx = len_eff - LW'(k + 2);
    spm_cell u_cell (
      .clk         (clk),
      .shift_en    (accept),
      .byte_in     (chain[k]),
      .care        (care),
      .expect_byte (spm_pkg::pattern_byte(pat, exp_idx)),
      .byte_out    (chain[k+1]),
      .eq          (cell_eq[k])
    );
  end

  assign fill_ok = ((LW+1)'(seen_eff) + (LW+1)'(1)) >= (LW+1)'(len_eff);
  assign hit     = fill_ok && &cell_eq &&
                   (spm_pkg::pattern_byte(pat, len_eff - LW'(1)) == text_byte);

  assign count_next = (hit && (count_eff != '1)) ? count_eff + 1'b1 : count_eff;

  always_comb begin
    res_in.found = hit;
    res_in.start = hit ? pos_eff - spm_pkg::POS_W'(len_eff - LW'(1)) : '0;
    res_in.total = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen     <= '0;
      text_position  <= '0;
      matches_so_far <= '0;
    end else if (accept) begin
      bytes_seen     <= (32'(seen_eff) < spm_pkg::WIN) ? seen_eff + 1'b1 : seen_eff;
      text_position  <= pos_eff + 1'b1;
      matches_so_far <= count_next;
    end
  end

  spm_out_buf u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .res_in     (res_in),
    .can_load   (can_load),
    .skid_valid (skid_valid),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res_out    (res_out)
  );

  assign match_found = res_out.found;
  assign match_start = res_out.start;
  assign match_total = res_out.total;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a word while the output register is empty");

  a_skid_after_stall: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> $past(out_valid && !out_ready))
    else $error("skid filled without an output stall");

  a_found_counted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && match_found) |-> (match_total != '0))
    else $error("match reported with a zero running count");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench for the streaming pattern matcher: random and directed text against a model
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 18;

  // tracks window, position and match count, and holds the match words still due
  class kmp_tracker;
    logic [63:0]                 pat_lo;
    logic [63:0]                 pat_hi;
    logic [4:0]                  pat_len;
    logic [7:0]                  recent [spm_pkg::WIN];
    int                          seen;
    logic [spm_pkg::POS_W-1:0]   pos;
    logic [spm_pkg::TOTAL_W-1:0] total;
    spm_pkg::result_t            pending [$];
    int                          errors;

    function new();
      pat_lo  = '0;
      pat_hi  = '0;
      pat_len = 5'd1;
      errors  = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (recent[i]) recent[i] = 8'h00;
      seen  = 0;
      pos   = '0;
      total = '0;
    endfunction

    function void set_reg(logic [spm_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        spm_pkg::REG_PATTERN_LOW:    pat_lo  = data;
        spm_pkg::REG_PATTERN_HIGH:   pat_hi  = data;
        spm_pkg::REG_PATTERN_LENGTH: pat_len = data[4:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] pattern_at(int idx);
      if (idx < 8) return pat_lo[8*idx +: 8];
      return pat_hi[8*(idx-8) +: 8];
    endfunction

    function void take_byte(logic [7:0] c, logic sot);
      int               len;
      logic             hit;
      spm_pkg::result_t r;
      if (sot) clear_text();
      len = int'(pat_len);
      if (len == 0) len = 1;
      if (len > spm_pkg::PAT_MAX) len = spm_pkg::PAT_MAX;
      hit = 1'b0;
      if (seen + 1 >= len && pattern_at(len - 1) == c) begin
        hit = 1'b1;
        for (int k = 1; k < len; k++) begin
          if (recent[k-1] != pattern_at(len - 1 - k)) hit = 1'b0;
        end
      end
      r.found = hit;
      r.start = '0;
      if (hit) begin
        r.start = pos - spm_pkg::POS_W'(len - 1);
        if (total != '1) total++;
      end
      r.total = total;
      pending = {pending, r};
      for (int j = spm_pkg::WIN - 1; j >= 1; j--) recent[j] = recent[j-1];
      recent[0] = c;
      if (seen < spm_pkg::WIN) seen++;
      pos++;
    endfunction

    function void check_match(logic found, logic [spm_pkg::POS_W-1:0] start,
                              logic [spm_pkg::TOTAL_W-1:0] tot);
      spm_pkg::result_t e;
      if (pending.size() == 0) begin
        $error("result word with no text byte pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (found !== e.found) begin
        $error("match_found: expected %0d, got %0d", e.found, found);
        errors++;
      end
      if (start !== e.start) begin
        $error("match_start: expected %0d, got %0d", e.start, start);
        errors++;
      end
      if (tot !== e.total) begin
        $error("match_total: expected %0d, got %0d", e.total, tot);
        errors++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst           = 1'b1;
  logic                          cfg_valid     = 1'b0;
  logic                          cfg_ready;
  logic [spm_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
  logic [spm_pkg::CFG_W-1:0]     cfg_data      = '0;
  logic                          in_valid      = 1'b0;
  logic                          in_ready;
  logic [7:0]                    text_byte     = 8'h00;
  logic                          start_of_text = 1'b0;
  logic                          out_valid;
  logic                          out_ready     = 1'b0;
  logic                          match_found;
  logic [spm_pkg::POS_W-1:0]     match_start;
  logic [spm_pkg::TOTAL_W-1:0]   match_total;

  kmp_tracker sb = new();
  int         send_idle  = 0;
  int         recv_stall = 0;
  int         hold_left  = 0;
  int         cycles     = 0;
  logic [7:0] pat_bytes [spm_pkg::PAT_MAX];
  int         len_plan [NUM_PHASES] = '{16, 31, 0, 1, 2, 3, 5, 8, 4, 16, 7, 3, 2, 12, 6, 9,
                                        1, 20};

  streaming_pattern_matcher DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .text_byte(text_byte),
    .start_of_text(start_of_text),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .match_found(match_found),
    .match_start(match_start),
    .match_total(match_total)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver: long hold-off when asked, otherwise random stalls
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_stall);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_match(match_found, match_start, match_total);
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic push_text_byte(input logic [7:0] c, input logic sot);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    text_byte     = c;
    start_of_text = sot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_byte(c, sot);
  endtask

  task automatic load_register(input logic [spm_pkg::CFG_IDX_W-1:0] idx,
                               input logic [63:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // stop input and wait until every match word has come back
  task automatic settle_matcher();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_text(input int count, input int eff_len);
    int   n;
    int   cut;
    logic sot;
    n = 0;
    while (n < count) begin
      sot = ($urandom_range(79) == 0);
      if ($urandom_range(99) < 35) begin
        // a copy of the pattern, sometimes cut short
        cut = ($urandom_range(3) == 0) ? $urandom_range(eff_len, 1) : eff_len;
        for (int i = 0; i < cut; i++) push_text_byte(pat_bytes[i], (i == 0) && sot);
        n += cut;
      end else if ($urandom_range(99) < 85) begin
        push_text_byte(pat_bytes[$urandom_range(eff_len - 1, 0)], sot);
        n++;
      end else begin
        push_text_byte(8'($urandom_range(255)), sot);
        n++;
      end
    end
  endtask

  initial begin
    logic [7:0]  alpha [3];
    logic [63:0] lo;
    logic [63:0] hi;
    int          len;
    int          eff;
    int          mode;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // default pattern is a single zero byte
    push_text_byte(8'h00, 1'b1);
    push_text_byte(8'hFF, 1'b0);
    settle_matcher();

    // overlapping matches and a short text; upper data bits must be ignored
    load_register(spm_pkg::REG_PATTERN_LOW, 64'h0000_0000_4241_4241);
    load_register(spm_pkg::REG_PATTERN_HIGH, 64'h0);
    load_register(spm_pkg::REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE4);
    push_text_byte(8'h41, 1'b1);
    push_text_byte(8'h42, 1'b0);
    push_text_byte(8'h41, 1'b0);
    push_text_byte(8'h42, 1'b0);
    push_text_byte(8'h41, 1'b0);
    push_text_byte(8'h42, 1'b0);
    settle_matcher();

    // full length pattern of all ones
    load_register(spm_pkg::REG_PATTERN_LOW, '1);
    load_register(spm_pkg::REG_PATTERN_HIGH, '1);
    load_register(spm_pkg::REG_PATTERN_LENGTH, 64'd16);
    push_text_byte(8'hFF, 1'b1);
    repeat (15) push_text_byte(8'hFF, 1'b0);
    settle_matcher();

    // length zero acts as length one
    load_register(spm_pkg::REG_PATTERN_LENGTH, 64'd0);
    push_text_byte(8'hFF, 1'b0);
    settle_matcher();

    for (int p = 0; p < NUM_PHASES; p++) begin
      foreach (alpha[i]) alpha[i] = 8'($urandom_range(255));
      if (p == 1) begin
        alpha[0] = 8'h00;
        alpha[1] = 8'hFF;
        alpha[2] = 8'h00;
      end
      for (int i = 0; i < spm_pkg::PAT_MAX; i++) begin
        pat_bytes[i] = alpha[$urandom_range(2)];
        if (i < 8) lo[8*i +: 8] = pat_bytes[i];
        else hi[8*(i-8) +: 8] = pat_bytes[i];
      end
      len = len_plan[p];
      eff = (len == 0) ? 1 : (len > spm_pkg::PAT_MAX) ? spm_pkg::PAT_MAX : len;
      load_register(spm_pkg::REG_PATTERN_LOW, lo);
      load_register(spm_pkg::REG_PATTERN_HIGH, hi);
      load_register(spm_pkg::REG_PATTERN_LENGTH, {$urandom(), 27'($urandom()), 5'(len)});

      mode = p % 4;
      send_idle  = (mode == 1) ? 83 : (mode == 3) ? 26 : 0;
      recv_stall = (mode == 2) ? 83 : (mode == 3) ? 26 : 0;
      // one long receiver hold-off so the input side backs up
      if (p == 4) hold_left = 250;

      random_text(95, eff);
      settle_matcher();
    end

    send_idle  = 0;
    recv_stall = 0;
    settle_matcher();
    if (sb.pending.size() != 0) begin
      $error("%0d match words never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
